// ===== hdl/str_pkg.sv =====
// ----------------------------------------------------------------------------
// str_pkg
// shared types, register indexes and arithmetic for the tonal residue block
// ----------------------------------------------------------------------------
package str_pkg;

    localparam int VALUE_W = 24;
    localparam int COEFF_W = 16;
    localparam int GAIN_W  = 16;
    localparam int BINS_W  = 11;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS      = 2'd2;

    localparam logic [GAIN_W-1:0] LEVEL_RESET = 16'd4096;
    localparam logic [BINS_W-1:0] BINS_RESET  = 11'd513;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RESP  = 10'b0000000100,
        S_FRD   = 10'b0000001000,
        S_FCALC = 10'b0000010000,
        S_BRD   = 10'b0000100000,
        S_BCALC = 10'b0001000000,
        S_BENV  = 10'b0010000000,
        S_CRD   = 10'b0100000000,
        S_CWR   = 10'b1000000000
    } state_t;

    // c + (n - c) * s, rounded half up, floor
    function automatic value_t blend(input value_t n, input value_t c,
                                     input logic [COEFF_W-1:0] s);
        logic signed [VALUE_W:0] diff;
        logic signed [41:0]      acc;
        diff = {n[VALUE_W-1], n} - {c[VALUE_W-1], c};
        acc  = $signed({{2{c[VALUE_W-1]}}, c, 16'b0})
             + diff * $signed({1'b0, s}) + 42'sd32768;
        return acc[39:16];
    endfunction

    // raw - (gain * env) rounded, clipped to [0, max]
    function automatic value_t residue(input value_t raw, input value_t env,
                                       input logic [GAIN_W-1:0] gain);
        logic signed [40:0] prod;
        logic signed [29:0] diff;
        value_t             res;
        prod = $signed({1'b0, gain}) * env + 41'sd2048;
        diff = {{6{raw[VALUE_W-1]}}, raw} - {prod[40], prod[40:12]};
        if (diff < 0) begin
            res = '0;
        end else if (diff > 30'sd8388607) begin
            res = 24'sd8388607;
        end else begin
            res = diff[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/spectral_tonal_residue.sv =====
// ----------------------------------------------------------------------------
// spectral_tonal_residue
// spectral envelope subtraction with a zero-phase one-pole smoother
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one frame value per beat, s_frame_end on the last one.
//   m_ channel returns one beat per input beat: the processed value at the
//   same position of the previous frame, m_result_last on its last position.
//   each ordinary beat passes through a done memory read (S_IDLE), then the
//   output load (S_RESP). at a frame end the frame is processed before the
//   next beat is taken: a forward and a backward pass over the first
//   nb = min(bin_count, len) positions, then a copy of the remaining raw values.
//   the forward smoothing pass is held in the done memory until the
//   backward pass overwrites each entry with its residue.
//   after reset the done memory is cleared entry by entry, during which
//   no beat is taken; configuration writes are taken at any time.
//   the output register holds one result; a stalled receiver stops input
//   once that register is full.
//   cfg_we writes cfg_data into register cfg_index (0 smoothing, 1 level,
//   2 bin count).
// ----------------------------------------------------------------------------
module spectral_tonal_residue #(
    parameter int FRAME_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [str_pkg::VALUE_W-1:0] s_sample_value,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [str_pkg::VALUE_W-1:0] m_result_value,
    output logic                          m_result_last,
    input  logic                          cfg_we,
    input  logic [str_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [str_pkg::CFG_W-1:0]     cfg_data
);
    import str_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int LW = AW + 1;
    localparam int CW = (LW > BINS_W) ? LW : BINS_W;
    localparam logic [AW-1:0] LAST_POS = AW'(FRAME_DEPTH - 1);

    value_t raw_mem  [FRAME_DEPTH];
    value_t done_mem [FRAME_DEPTH];

    value_t raw_rd, done_rd;
    logic [AW-1:0] raw_raddr, done_raddr;
    logic          raw_we, done_we;
    logic [AW-1:0] raw_waddr, done_waddr;
    value_t        raw_wdata, done_wdata;

    state_t state_reg, state_next;
    logic [COEFF_W-1:0] coeff_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [BINS_W-1:0]  bins_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [LW-1:0] prev_len_reg, prev_len_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] nb_reg, nb_next;
    logic          end_reg, end_next;
    logic          last_reg, last_next;
    value_t        carry_reg, carry_next;
    value_t        rawq_reg, rawq_next;
    logic          mv_reg, mv_next;
    value_t        mval_reg, mval_next;
    logic          mlast_reg, mlast_next;

    logic          accept;
    logic [LW-1:0] cur_len;
    logic [CW-1:0] bins_ext, len_ext;
    value_t        fwd_val, bwd_val;

    assign s_ready        = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign accept         = s_valid && s_ready;
    assign m_valid        = mv_reg;
    assign m_result_value = mval_reg;
    assign m_result_last  = mlast_reg;

    assign cur_len  = {1'b0, pos_reg} + LW'(1);
    assign bins_ext = CW'(bins_reg);
    assign len_ext  = CW'(cur_len);

    assign fwd_val = (idx_reg == '0) ? raw_rd : blend(carry_reg, raw_rd, coeff_reg);
    assign bwd_val = ({1'b0, idx_reg} == nb_reg - LW'(1)) ? done_rd
                   : blend(carry_reg, done_rd, coeff_reg);

    always_ff @(posedge aclk) begin
        if (raw_we) begin
            raw_mem[raw_waddr] <= raw_wdata;
        end
        raw_rd <= raw_mem[raw_raddr];
        if (done_we) begin
            done_mem[done_waddr] <= done_wdata;
        end
        done_rd <= done_mem[done_raddr];
    end

    always_comb begin
        raw_we     = accept;
        raw_waddr  = pos_reg;
        raw_wdata  = s_sample_value;
        raw_raddr  = idx_reg;
        done_raddr = (state_reg == S_IDLE) ? pos_reg : idx_reg;
        done_waddr = idx_reg;
        done_we    = 1'b0;
        done_wdata = '0;
        unique case (state_reg)
            S_CLR: begin
                done_we = 1'b1;
            end
            S_FCALC: begin
                done_we    = 1'b1;
                done_wdata = fwd_val;
            end
            S_BENV: begin
                done_we    = 1'b1;
                done_wdata = residue(rawq_reg, carry_reg, gain_reg);
            end
            S_CWR: begin
                done_we    = 1'b1;
                done_wdata = raw_rd;
            end
            default: begin
                done_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        prev_len_next = prev_len_reg;
        len_next      = len_reg;
        nb_next       = nb_reg;
        end_next      = end_reg;
        last_next     = last_reg;
        carry_next    = carry_reg;
        rawq_next     = rawq_reg;
        mv_next       = mv_reg && !m_ready;
        mval_next     = mval_reg;
        mlast_next    = mlast_reg;
        unique case (state_reg)
            S_CLR: begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_POS) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    end_next   = s_frame_end || (pos_reg == LAST_POS);
                    last_next  = (prev_len_reg != '0) && (cur_len == prev_len_reg);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                mv_next    = 1'b1;
                mval_next  = done_rd;
                mlast_next = last_reg;
                if (end_reg) begin
                    prev_len_next = cur_len;
                    len_next      = cur_len;
                    nb_next       = (bins_ext >= len_ext) ? cur_len : LW'(bins_ext);
                    pos_next      = '0;
                    idx_next      = '0;
                    state_next    = (bins_reg == '0) ? S_CRD : S_FRD;
                end else begin
                    pos_next   = pos_reg + AW'(1);
                    state_next = S_IDLE;
                end
            end
            S_FRD: begin
                state_next = S_FCALC;
            end
            S_FCALC: begin
                carry_next = fwd_val;
                if ({1'b0, idx_reg} == nb_reg - LW'(1)) begin
                    state_next = S_BRD;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_FRD;
                end
            end
            S_BRD: begin
                state_next = S_BCALC;
            end
            S_BCALC: begin
                carry_next = bwd_val;
                rawq_next  = raw_rd;
                state_next = S_BENV;
            end
            S_BENV: begin
                if (idx_reg == '0) begin
                    if (nb_reg == len_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = nb_reg[AW-1:0];
                        state_next = S_CRD;
                    end
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_BRD;
                end
            end
            S_CRD: begin
                state_next = S_CWR;
            end
            S_CWR: begin
                if ({1'b0, idx_reg} == len_reg - LW'(1)) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_CRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            pos_reg      <= '0;
            idx_reg      <= '0;
            prev_len_reg <= '0;
            mv_reg       <= 1'b0;
            coeff_reg    <= '0;
            gain_reg     <= LEVEL_RESET;
            bins_reg     <= BINS_RESET;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            prev_len_reg <= prev_len_next;
            mv_reg       <= mv_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SMOOTHING: coeff_reg <= cfg_data[COEFF_W-1:0];
                    REG_LEVEL:     gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_BINS:      bins_reg  <= cfg_data[BINS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        nb_reg    <= nb_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
        carry_reg <= carry_next;
        rawq_reg  <= rawq_next;
        mval_reg  <= mval_next;
        mlast_reg <= mlast_next;
    end

endmodule

// ===== hdl/str_checker.sv =====
// ----------------------------------------------------------------------------
// str_checker
// port-level checks for the tonal residue block
// ----------------------------------------------------------------------------
module str_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [str_pkg::VALUE_W-1:0] m_result_value,
    input logic                          m_result_last
);
    import str_pkg::*;

    // output beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_result_last))
        else $error("stalled output beat changed");

    // input taken only when the output register can free up
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("input beat taken with output full");

    // every input beat yields an output beat, loaded in the S_RESP state
    a_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("missing output beat");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind spectral_tonal_residue str_checker u_str_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_result_last  (m_result_last)
);
